// ----- rtl/tlvw_pkg.sv -----
// Shared types, codes and constants of the TLV metadata walker.
// Used by tlvw_cell and tlv_metadata_walker; depends on nothing else.
package tlvw_pkg;

    // Default table depth and fixed header sizes in bytes.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int INFO_BYTES      = 4;
    localparam int ENTRY_HDR_BYTES = 4;

    // Stream widths.
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;

    // Configuration register indexes.
    localparam logic CFG_EXPECTED_MAGIC = 1'b0;
    localparam logic CFG_MAX_AREA_LEN   = 1'b1;

    // Request kinds carried in tuser.
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_FIND  = 2'd2
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_INVALID   = 2'd2,
        STAT_FLASH     = 2'd3
    } status_t;

    // Search token handed from cell to cell along the table.
    typedef struct packed {
        logic        valid;
        logic [15:0] query;
        logic        found;
        logic [15:0] hit_type;
        logic [15:0] hit_len;
        logic [31:0] hit_addr;
    } token_t;

    // One result, packed so that status lands in the lowest bits.
    typedef struct packed {
        logic [31:0] hit_addr;
        logic [15:0] hit_len;
        logic [15:0] hit_type;
        logic [4:0]  stored_entries;
        logic [31:0] next_read_addr;
        logic        want_header;
        logic [1:0]  status;
    } result_t;

endpackage

// ----- rtl/tlvw_cell.sv -----
// One table cell of the TLV metadata walker: holds one recorded entry and
// checks the passing search token against it. Depends on tlvw_pkg.
module tlvw_cell
    import tlvw_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int IW  = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [15:0]   wr_type,
    input  logic [15:0]   wr_len,
    input  logic [31:0]   wr_addr,
    input  logic [CW-1:0] count,
    input  token_t        tok_in,
    output token_t        tok_out
);

    localparam logic [IW-1:0] IDX_W = IW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [15:0] type_reg;
    logic [15:0] len_reg;
    logic [31:0] addr_reg;
    token_t      tok_reg;
    token_t      tok_next;
    logic        in_use;

    // Store the entry when the walker records it at this cell's index.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == IDX_W)) begin
            type_reg <= wr_type;
            len_reg  <= wr_len;
            addr_reg <= wr_addr;
        end
    end

    // The first occupied cell whose type matches claims the token.
    assign in_use = (count > IDX_C);

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && in_use && (type_reg == tok_in.query)) begin
            tok_next.found    = 1'b1;
            tok_next.hit_type = type_reg;
            tok_next.hit_len  = len_reg;
            tok_next.hit_addr = addr_reg;
        end
    end

    // Hand the token on to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/tlv_metadata_walker.sv -----
// Top level of the TLV metadata walker: request decode, walk control,
// output register and the row of table cells. Depends on tlvw_pkg, tlvw_cell.
//
// Usage: requests arrive on the s_ stream, one result per request leaves on
// the m_ stream. tuser selects the request kind: start (checks the area info
// header and empties the table), entry header (records one entry or ends the
// walk) or find (looks up the first recorded entry of a type).
// Start and entry header results are in the output register in the cycle
// after acceptance. A find request sends a search token down the row of
// MAX_ENTRIES cells, one cell per cycle; found_reg captures it from the last
// cell and the result goes to the output register once that is empty or read.
// One request is in work at a time. A request is taken while the walker is
// idle and the output register is empty or being read, so with the receiver
// ready a start or entry header request is taken every cycle; a find blocks
// new requests until its result is written. A stalled receiver holds the
// result and the input. The configuration port (cfg_we, cfg_index, cfg_wdata)
// writes the expected magic and the maximum area length; the user must use it
// only while the block is idle; the block itself does not enforce this.
// Reset (aresetn low, synchronous) closes the walk, empties the table and
// clears the output; expected magic resets to 0 and maximum length to 65535.
module tlv_metadata_walker
    import tlvw_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_wdata,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: area_addr[31:0], read_failed, header_magic[31:0],
    // area_len[15:0], entry_type[15:0], entry_len[15:0], query_type[15:0], zeros
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser from bit 0: kind[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: status[1:0], want_header, next_read_addr[31:0],
    // stored_entries[4:0], hit_type[15:0], hit_len[15:0], hit_addr[31:0]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        FSM_IDLE   = 3'b001,
        FSM_SEARCH = 3'b010,
        FSM_DONE   = 3'b100
    } fsm_t;

    // Request fields.
    logic [1:0]  kind;
    logic [31:0] area_addr;
    logic        read_failed;
    logic [31:0] header_magic;
    logic [15:0] area_len;
    logic [15:0] entry_type;
    logic [15:0] entry_len;
    logic [15:0] query_type;

    assign kind         = s_tuser[1:0];
    assign area_addr    = s_tdata[31:0];
    assign read_failed  = s_tdata[32];
    assign header_magic = s_tdata[64:33];
    assign area_len     = s_tdata[80:65];
    assign entry_type   = s_tdata[96:81];
    assign entry_len    = s_tdata[112:97];
    assign query_type   = s_tdata[128:113];

    // State.
    fsm_t          state_reg, state_next;
    logic [31:0]   magic_reg;
    logic [15:0]   max_len_reg;
    logic [31:0]   area_base_reg, area_base_next;
    logic [15:0]   area_len_reg, area_len_next;
    logic [16:0]   cursor_reg, cursor_next;
    logic          walking_reg, walking_next;
    logic [CW-1:0] count_reg, count_next;
    token_t        found_reg;
    result_t       result_reg;
    logic          m_tvalid_reg;

    logic          out_free;
    logic          accept;
    logic          wr_en;
    logic [31:0]   wr_addr;
    logic [17:0]   entry_end;
    logic [17:0]   entry_end_rnd;
    logic [1:0]    simple_status;
    result_t       simple_result;
    result_t       find_result;
    token_t        chain [0:MAX_ENTRIES];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == FSM_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= '0;
            max_len_reg <= 16'hFFFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EXPECTED_MAGIC: magic_reg   <= cfg_wdata;
                CFG_MAX_AREA_LEN:   max_len_reg <= cfg_wdata[15:0];
                default:            magic_reg   <= magic_reg;
            endcase
        end
    end

    // Entry arithmetic: end of the value and the cursor rounded up to four bytes.
    assign entry_end     = {1'b0, cursor_reg} + 18'(ENTRY_HDR_BYTES) + {2'b00, entry_len};
    assign entry_end_rnd = (entry_end + 18'd3) & ~18'd3;
    assign wr_addr       = area_base_reg + 32'(cursor_reg) + 32'(ENTRY_HDR_BYTES);

    // Next walk state for start and entry header requests.
    always_comb begin
        area_base_next = area_base_reg;
        area_len_next  = area_len_reg;
        cursor_next    = cursor_reg;
        walking_next   = walking_reg;
        count_next     = count_reg;
        simple_status  = STAT_INVALID;
        wr_en          = 1'b0;
        unique case (kind)
            KIND_START: begin
                area_base_next = area_addr;
                area_len_next  = '0;
                cursor_next    = '0;
                walking_next   = 1'b0;
                count_next     = '0;
                priority if (read_failed) begin
                    simple_status = STAT_FLASH;
                end else if (header_magic != magic_reg) begin
                    simple_status = STAT_NOT_FOUND;
                end else if ((area_len < 16'(INFO_BYTES)) || (area_len > max_len_reg)) begin
                    simple_status = STAT_INVALID;
                end else begin
                    simple_status = STAT_OK;
                    area_len_next = area_len;
                    cursor_next   = 17'(INFO_BYTES);
                    walking_next  = (17'(INFO_BYTES + ENTRY_HDR_BYTES) <= {1'b0, area_len});
                end
            end
            KIND_ENTRY: begin
                if (walking_reg) begin
                    simple_status = STAT_OK;
                    if (read_failed || ((entry_type == '0) && (entry_len == '0)) ||
                        (entry_end > {2'b00, area_len_reg}) || (count_reg >= MAX_C)) begin
                        walking_next = 1'b0;
                    end else begin
                        wr_en        = 1'b1;
                        count_next   = count_reg + 1'b1;
                        cursor_next  = entry_end_rnd[16:0];
                        walking_next = ({1'b0, entry_end_rnd[16:0]} + 18'(ENTRY_HDR_BYTES)
                                        <= {2'b00, area_len_reg}) &&
                                       ((count_reg + 1'b1) < MAX_C);
                    end
                end
            end
            default: begin
                simple_status = STAT_INVALID;
            end
        endcase
    end

    // Result of a start or entry header request.
    always_comb begin
        simple_result                = '0;
        simple_result.status         = simple_status;
        simple_result.want_header    = walking_next;
        simple_result.next_read_addr = walking_next ? (area_base_next + 32'(cursor_next)) : '0;
        simple_result.stored_entries = 5'(count_next);
    end

    // Result of a completed search.
    always_comb begin
        find_result                = '0;
        find_result.status         = found_reg.found ? STAT_OK : STAT_NOT_FOUND;
        find_result.want_header    = walking_reg;
        find_result.next_read_addr = walking_reg ? (area_base_reg + 32'(cursor_reg)) : '0;
        find_result.stored_entries = 5'(count_reg);
        if (found_reg.found) begin
            find_result.hit_type = found_reg.hit_type;
            find_result.hit_len  = found_reg.hit_len;
            find_result.hit_addr = found_reg.hit_addr;
        end
    end

    // Walk registers update on every accepted start or entry header request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_base_reg <= '0;
            area_len_reg  <= '0;
            cursor_reg    <= '0;
            walking_reg   <= 1'b0;
            count_reg     <= '0;
        end else if (accept && (kind != KIND_FIND)) begin
            area_base_reg <= area_base_next;
            area_len_reg  <= area_len_next;
            cursor_reg    <= cursor_next;
            walking_reg   <= walking_next;
            count_reg     <= count_next;
        end
    end

    // Search token launched into the first cell.
    always_comb begin
        chain[0]       = '0;
        chain[0].valid = accept && (kind == KIND_FIND);
        chain[0].query = query_type;
    end

    // Row of table cells.
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        tlvw_cell #(
            .IDX (i),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (accept && wr_en),
            .wr_idx  (count_reg[IW-1:0]),
            .wr_type (entry_type),
            .wr_len  (entry_len),
            .wr_addr (wr_addr),
            .count   (count_reg),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // Control sequence: idle, token in flight, search result waiting.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept && (kind == KIND_FIND)) begin
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH: begin
                if (chain[MAX_ENTRIES].valid) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the token as it leaves the last cell.
    always_ff @(posedge aclk) begin
        if ((state_reg == FSM_SEARCH) && chain[MAX_ENTRIES].valid) begin
            found_reg <= chain[MAX_ENTRIES];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept && (kind != KIND_FIND)) begin
            m_tvalid_reg <= 1'b1;
            result_reg   <= simple_result;
        end else if ((state_reg == FSM_DONE) && out_free) begin
            m_tvalid_reg <= 1'b1;
            result_reg   <= find_result;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

endmodule

// ----- sim/tlvw_checker.sv -----
// Request format and result checker for the TLV metadata walker testbench.
// Depends on tlvw_pkg; the checker watches both streams and the register port,
// keeps its own model of the walker and compares every result it sees.
package tlvw_tb_pkg;

    import tlvw_pkg::*;

    // Request payload as packed into s_tdata, lowest field last in the list.
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] query_type;
        logic [15:0] entry_len;
        logic [15:0] entry_type;
        logic [15:0] area_len;
        logic [31:0] header_magic;
        logic        read_failed;
        logic [31:0] area_addr;
    } tlv_req_t;

    // Cycles to let pass once the last result is in, covering a full search.
    localparam int SETTLE_CYCLES = MAX_ENTRIES_DEF + 6;

endpackage

module tlvw_checker
    import tlvw_pkg::*;
    import tlvw_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies.
    logic [31:0] magic_reg;
    logic [15:0] max_len_reg;

    // Walk state and the entry table.
    logic [31:0] area_base;
    logic [15:0] area_length;
    logic [31:0] cursor;
    logic        walking;
    logic [4:0]  entry_count;
    logic [15:0] tab_type [MAX_ENTRIES_DEF];
    logic [15:0] tab_len  [MAX_ENTRIES_DEF];
    logic [31:0] tab_addr [MAX_ENTRIES_DEF];

    result_t awaited_results [$];

    // The walk stays open while another header fits and the table has room.
    function automatic logic header_fits();
        return (cursor + ENTRY_HDR_BYTES <= 32'(area_length)) &&
               (entry_count < MAX_ENTRIES_DEF);
    endfunction

    // Apply one request to the model and work out the result it gives.
    task automatic walk_step(input logic [1:0] kind, input tlv_req_t rq,
                             output result_t res);
        logic [31:0] entry_end;
        logic        found;
        res        = '0;
        res.status = STAT_INVALID;
        case (kind)
            KIND_START: begin
                entry_count = '0;
                walking     = 1'b0;
                cursor      = '0;
                area_base   = rq.area_addr;
                area_length = '0;
                if (rq.read_failed) begin
                    res.status = STAT_FLASH;
                end else if (rq.header_magic != magic_reg) begin
                    res.status = STAT_NOT_FOUND;
                end else if (rq.area_len < INFO_BYTES || rq.area_len > max_len_reg) begin
                    res.status = STAT_INVALID;
                end else begin
                    area_length = rq.area_len;
                    cursor      = INFO_BYTES;
                    walking     = header_fits();
                    res.status  = STAT_OK;
                end
            end
            KIND_ENTRY: begin
                // An entry header outside an open walk is refused.
                if (walking) begin
                    res.status = STAT_OK;
                    entry_end  = cursor + ENTRY_HDR_BYTES + 32'(rq.entry_len);
                    if (rq.read_failed || (rq.entry_type == 0 && rq.entry_len == 0) ||
                        entry_end > 32'(area_length) || entry_count >= MAX_ENTRIES_DEF) begin
                        walking = 1'b0;
                    end else begin
                        tab_type[entry_count] = rq.entry_type;
                        tab_len[entry_count]  = rq.entry_len;
                        tab_addr[entry_count] = area_base + cursor + ENTRY_HDR_BYTES;
                        entry_count           = entry_count + 1'b1;
                        cursor                = (entry_end + 32'd3) & ~32'd3;
                        walking               = header_fits();
                    end
                end
            end
            KIND_FIND: begin
                // First recorded entry of the type wins.
                found      = 1'b0;
                res.status = STAT_NOT_FOUND;
                for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
                    if (!found && i < entry_count && tab_type[i] == rq.query_type) begin
                        found        = 1'b1;
                        res.status   = STAT_OK;
                        res.hit_type = tab_type[i];
                        res.hit_len  = tab_len[i];
                        res.hit_addr = tab_addr[i];
                    end
                end
            end
            default: ;
        endcase
        res.want_header    = walking;
        res.next_read_addr = walking ? area_base + cursor : 32'd0;
        res.stored_entries = entry_count;
    endtask

    task automatic mismatch(input string field, input logic [31:0] exp_val,
                            input logic [31:0] act_val);
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, exp_val, act_val);
        errors++;
    endtask

    // Results are compared before new requests are predicted, so a result can
    // never be matched against a request taken at the same edge.
    always @(posedge aclk) begin
        result_t exp_res;
        result_t got_res;
        result_t new_res;
        if (!aresetn) begin
            magic_reg   = '0;
            max_len_reg = 16'hFFFF;
            area_base   = '0;
            area_length = '0;
            cursor      = '0;
            walking     = 1'b0;
            entry_count = '0;
            errors      = 0;
            awaited_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EXPECTED_MAGIC: magic_reg   = cfg_wdata;
                    CFG_MAX_AREA_LEN:   max_len_reg = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got_res = result_t'(m_tdata);
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result %0h arrived with none expected", $time, m_tdata);
                    errors++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (got_res.status !== exp_res.status)
                        mismatch("status", 32'(exp_res.status), 32'(got_res.status));
                    if (got_res.want_header !== exp_res.want_header)
                        mismatch("want_header", 32'(exp_res.want_header),
                                 32'(got_res.want_header));
                    if (got_res.next_read_addr !== exp_res.next_read_addr)
                        mismatch("next_read_addr", exp_res.next_read_addr,
                                 got_res.next_read_addr);
                    if (got_res.stored_entries !== exp_res.stored_entries)
                        mismatch("stored_entries", 32'(exp_res.stored_entries),
                                 32'(got_res.stored_entries));
                    if (got_res.hit_type !== exp_res.hit_type)
                        mismatch("hit_type", 32'(exp_res.hit_type), 32'(got_res.hit_type));
                    if (got_res.hit_len !== exp_res.hit_len)
                        mismatch("hit_len", 32'(exp_res.hit_len), 32'(got_res.hit_len));
                    if (got_res.hit_addr !== exp_res.hit_addr)
                        mismatch("hit_addr", exp_res.hit_addr, got_res.hit_addr);
                end
            end
            if (s_tvalid && s_tready) begin
                walk_step(s_tuser, tlv_req_t'(s_tdata), new_res);
                awaited_results.push_back(new_res);
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ----- sim/tb_tlv_metadata_walker.sv -----
// Testbench top for the TLV metadata walker: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on tlvw_pkg, the checker file
// (tlvw_tb_pkg, tlvw_checker) and the walker RTL.
module tb_tlv_metadata_walker;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvw_pkg::*;
    import tlvw_tb_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int HOLD_CYCLES = 300;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int errors;
    int pending;

    // Stimulus-side view of the registers and of the pacing.
    int          requests_sent = 0;
    int          hold_req      = 0;
    bit          no_idle       = 1'b0;
    logic [31:0] cur_magic     = '0;
    logic [15:0] cur_max       = 16'hFFFF;

    always #2 aclk = ~aclk;

    tlv_metadata_walker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tlvw_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic tlv_req_t random_fields();
        tlv_req_t rq;
        rq              = '0;
        rq.area_addr    = $urandom;
        rq.read_failed  = 1'($urandom_range(0, 1));
        rq.header_magic = $urandom;
        rq.area_len     = 16'($urandom);
        rq.entry_type   = 16'($urandom);
        rq.entry_len    = 16'($urandom);
        rq.query_type   = 16'($urandom);
        return rq;
    endfunction

    // Offer one request after a random gap and wait until it is taken.
    task automatic send(input kind_t kind, input tlv_req_t rq);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= rq;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic send_start(input logic [31:0] addr, input logic failed,
                              input logic [31:0] magic, input logic [15:0] len);
        tlv_req_t rq;
        rq              = random_fields();
        rq.area_addr    = addr;
        rq.read_failed  = failed;
        rq.header_magic = magic;
        rq.area_len     = len;
        send(KIND_START, rq);
    endtask

    task automatic send_entry(input logic failed, input logic [15:0] typ,
                              input logic [15:0] len);
        tlv_req_t rq;
        rq             = random_fields();
        rq.read_failed = failed;
        rq.entry_type  = typ;
        rq.entry_len   = len;
        send(KIND_ENTRY, rq);
    endtask

    task automatic send_find(input logic [15:0] query);
        tlv_req_t rq;
        rq            = random_fields();
        rq.query_type = query;
        send(KIND_FIND, rq);
    endtask

    // Find mostly among the small types that walks record.
    task automatic send_random_find();
        send_find(($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8)) : 16'($urandom));
    endtask

    // Stop offering, wait for every result, then let a full search time pass.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [15:0] max_len);
        settle();
        write_reg(CFG_EXPECTED_MAGIC, magic);
        write_reg(CFG_MAX_AREA_LEN, {16'h0, max_len});
        cur_magic = magic;
        cur_max   = max_len;
    endtask

    // A walk that mostly passes the info header check, with random entries,
    // finds in between and sometimes a sentinel at the end.
    task automatic random_walk();
        int          r;
        int          n_entries;
        logic [15:0] len;
        logic [15:0] typ;
        r = $urandom_range(0, 9);
        if (r < 7)
            len = 16'($urandom_range(4, 400));
        else if (r < 9)
            len = 16'($urandom_range(0, cur_max));
        else
            len = 16'($urandom);
        send_start($urandom, $urandom_range(0, 19) == 0,
                   ($urandom_range(0, 9) == 0) ? 32'($urandom) : cur_magic, len);
        n_entries = $urandom_range(0, 22);
        for (int i = 0; i < n_entries; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_random_find();
            typ = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
            len = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 24)) : 16'($urandom);
            send_entry($urandom_range(0, 39) == 0, typ, len);
        end
        if ($urandom_range(0, 1) == 0)
            send_entry(1'b0, 16'h0, 16'h0);
        repeat ($urandom_range(1, 4)) send_random_find();
    endtask

    // Result side: random stalls, plus one long hold-off each time hold_req changes.
    initial begin : result_sink
        int stall_left;
        int run_left;
        int hold_seen;
        stall_left = 0;
        run_left   = 0;
        hold_seen  = 0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen  = hold_req;
                stall_left = HOLD_CYCLES;
                run_left   = 1;
            end else if (stall_left == 0 && run_left == 0) begin
                stall_left = no_idle ? 0 : pick_gap();
                run_left   = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (run_left > 0) run_left--;
            end
        end
    end

    // Hard limit on the run.
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int session;
        int r;
        logic [31:0] magic;
        logic [15:0] max_len;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed part under reset settings: empty table, refused entry,
        // failed read, wrong magic, short area, then a walk at a wrapping base.
        send_find(16'h0);
        send_entry(1'b0, 16'h0001, 16'h0001);
        send_start(32'hFFFF_FFFF, 1'b1, 32'h0, 16'd64);
        send_start(32'h1000_0000, 1'b0, 32'hDEAD_BEEF, 16'd64);
        send_start(32'h1000_0000, 1'b0, 32'h0, 16'd3);
        send_start(32'hFFFF_FFF8, 1'b0, 32'h0, 16'hFFFF);
        send_entry(1'b0, 16'h0001, 16'h0001);
        send_entry(1'b0, 16'h0000, 16'h0005);
        send_entry(1'b0, 16'hFFFF, 16'h0000);
        send_find(16'hFFFF);
        send_entry(1'b1, 16'h0002, 16'h0002);
        send_entry(1'b0, 16'h0002, 16'h0002);
        send_find(16'h0000);
        send_find(16'h1234);

        // Smallest accepted area: no room for a single entry header.
        set_config(32'hFFFF_FFFF, 16'd4);
        send_start(32'h0, 1'b0, 32'hFFFF_FFFF, 16'd4);
        send_start(32'h0, 1'b0, 32'hFFFF_FFFF, 16'd5);
        send_entry(1'b0, 16'h0003, 16'h0000);

        // Entry ending exactly at the area end, the sentinel, an oversized value.
        set_config(32'h5A5A_0F0F, 16'hFFFF);
        send_start(32'h8000_0000, 1'b0, 32'h5A5A_0F0F, 16'd12);
        send_entry(1'b0, 16'h0007, 16'd4);
        send_start(32'h8000_0000, 1'b0, 32'h5A5A_0F0F, 16'd20);
        send_entry(1'b0, 16'h0000, 16'h0000);
        send_start(32'h7FFF_FFF0, 1'b0, 32'h5A5A_0F0F, 16'hFFFF);
        send_entry(1'b0, 16'h0003, 16'hFFFF);

        // Random part in sessions, with register changes, pauses and hold-offs.
        session = 0;
        while (requests_sent < ITEM_TARGET) begin
            session++;
            if (session % 12 == 0) begin
                r = $urandom_range(0, 3);
                magic = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
                r = $urandom_range(0, 5);
                max_len = (r == 0) ? 16'h0 : (r == 1) ? 16'd4 : (r == 2) ? 16'd3 :
                          (r == 3) ? 16'($urandom_range(4, 1000)) : 16'hFFFF;
                set_config(magic, max_len);
            end else if (session % 25 == 0) begin
                settle();
            end
            if (session == 20 || session == 70)
                hold_req++;
            no_idle = (session % 9 == 4);
            r = $urandom_range(0, 9);
            if (r < 8) begin
                random_walk();
            end else if (r < 9) begin
                repeat ($urandom_range(1, 4)) begin
                    send_start($urandom, 1'($urandom_range(0, 1)), $urandom,
                               16'($urandom));
                    send_entry(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                end
            end else begin
                repeat ($urandom_range(2, 8)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_entry(1'($urandom_range(0, 1)), 16'($urandom),
                                   16'($urandom));
                    else
                        send_find(16'($urandom));
                end
            end
        end
        no_idle = 1'b0;

        settle();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
